// ===== rtl/rsf_pkg.sv =====
// rsf_pkg: shared types and constants of the record slot fifo
// no dependencies; imported by rsf_ctrl, rsf_dp and record_slot_fifo_top
package rsf_pkg;

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int CNT_W  = 4;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SLOTS = 1'b0;
	localparam logic [IDX_W-1:0] REG_LIMIT = 1'b1;

	// configuration reset values
	localparam logic [CNT_W-1:0] SLOTS_RESET = 4'd8;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_TOOLONG = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_LEN,
		S_STREAM
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;        // input item accepted
		logic pop_first;   // length known and nonzero: fetch first byte
		logic pop_zero;    // length known and zero: emit single result
		logic stream_load; // move fetched byte into the result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;    // result register can take a new result
		logic held_zero;   // no record held
		logic len_zero;    // popped record has no bytes
		logic at_last;     // fetched byte is the last of the record
	} stat_t;

endpackage

// ===== rtl/rsf_ram.sv =====
// rsf_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
module rsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rsf_ctrl.sv =====
// rsf_ctrl: controller state machine of the record slot fifo
// depends on rsf_pkg; drives the datapath through cmd_t, watches stat_t
module rsf_ctrl import rsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  [1:0] operation,
	output logic  in_ready,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && stat.out_free && op_t'(operation) == OP_POP
						&& !stat.held_zero) begin
					state_nx = S_POP_LEN;
				end
			end
			S_POP_LEN: begin
				if (!stat.len_zero) begin
					state_nx = S_STREAM;
				end else if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			S_STREAM: begin
				if (stat.out_free && stat.at_last) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = stat.out_free;
				cmd.take = in_valid && stat.out_free;
			end
			S_POP_LEN: begin
				cmd.pop_first = !stat.len_zero;
				cmd.pop_zero  = stat.len_zero && stat.out_free;
			end
			S_STREAM: begin
				cmd.stream_load = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/rsf_dp.sv =====
// rsf_dp: datapath of the record slot fifo: pointers, count, partial record,
// configuration registers, byte and length memories, result register
// depends on rsf_pkg and rsf_ram
module rsf_dp import rsf_pkg::*; #(
	parameter int MAX_SLOTS  = 8,
	parameter int MAX_RECORD = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [1:0]        operation,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              byte_valid,
	input  logic              last_byte,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_valid,
	output logic              out_last,
	output logic [LEN_W-1:0]  record_length,
	output logic [CNT_W-1:0]  record_count
);

	localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int PW    = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
	localparam int DEPTH = MAX_SLOTS * MAX_RECORD;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = (SW + 1 > 5) ? SW + 1 : 5;

	// configuration
	logic [CNT_W-1:0] slots_q;
	logic [LEN_W-1:0] limit_q;

	// fifo control state
	logic [SW-1:0]    wr_ptr_q, rd_ptr_q, pop_slot_q;
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] partial_q;
	logic             overlong_q;
	logic [PW-1:0]    out_idx_q;

	// result register
	logic              res_valid_q;
	status_t           status_q;
	logic [BYTE_W-1:0] byte_q;
	logic              bvalid_q, last_q;
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;

	// memory ports
	logic              byte_we, byte_re, len_we, len_re;
	logic [AW-1:0]     byte_waddr, byte_raddr;
	logic [BYTE_W-1:0] byte_rd;
	logic [LEN_W-1:0]  len_rd;

	// working signals
	op_t              op;
	logic [EW-1:0]    eff_slots;
	logic [LEN_W-1:0] eff_limit;
	logic             full, byte_ok, ovl_new, commit, out_free;
	logic [LEN_W-1:0] part_inc;
	logic             res_load;
	status_t          res_status;
	logic [BYTE_W-1:0] res_byte;
	logic             res_bvalid, res_last;
	logic [LEN_W-1:0] res_len;
	logic [CNT_W-1:0] res_cnt;
	logic [CNT_W-1:0] count_nx;

	// flat byte address of a position inside a slot
	function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
			input logic [PW-1:0] p);
		return AW'(s) * AW'(MAX_RECORD) + AW'(p);
	endfunction

	// pointer advance with wrap at the effective slot count
	function automatic logic [SW-1:0] advance(input logic [SW-1:0] p,
			input logic [EW-1:0] wrap);
		logic [EW-1:0] nx;
		nx = EW'(p) + EW'(1);
		return (nx >= wrap) ? '0 : SW'(nx);
	endfunction

	assign op       = op_t'(operation);
	assign out_free = !res_valid_q || res_ready;

	// effective configuration
	always_comb begin
		if (slots_q == '0) begin
			eff_slots = EW'(1);
		end else if (EW'(slots_q) > EW'(MAX_SLOTS)) begin
			eff_slots = EW'(MAX_SLOTS);
		end else begin
			eff_slots = EW'(slots_q);
		end
		if (limit_q > LEN_W'(MAX_RECORD)) begin
			eff_limit = LEN_W'(MAX_RECORD);
		end else begin
			eff_limit = limit_q;
		end
	end

	// push decisions
	assign full     = EW'(count_q) >= eff_slots;
	assign byte_ok  = !overlong_q && (partial_q < eff_limit);
	assign part_inc = partial_q + LEN_W'(byte_valid && byte_ok);
	assign ovl_new  = overlong_q || (byte_valid && !byte_ok);
	assign commit   = cmd.take && op == OP_PUSH && last_byte && !full && !ovl_new;

	// byte memory ports
	assign byte_we    = cmd.take && op == OP_PUSH && byte_valid && byte_ok && !full;
	assign byte_waddr = slot_addr(wr_ptr_q, partial_q[PW-1:0]);
	assign byte_re    = cmd.pop_first || (cmd.stream_load && !stat.at_last);
	assign byte_raddr = cmd.pop_first ? slot_addr(pop_slot_q, '0)
		: slot_addr(pop_slot_q, out_idx_q + PW'(1));

	// length memory ports
	assign len_we = commit;
	assign len_re = cmd.take && op == OP_POP && count_q != '0;

	rsf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (data_byte),
		.re    (byte_re),
		.raddr (byte_raddr),
		.rdata (byte_rd)
	);

	rsf_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SLOTS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (wr_ptr_q),
		.wdata (part_inc),
		.re    (len_re),
		.raddr (rd_ptr_q),
		.rdata (len_rd)
	);

	// status to the controller
	always_comb begin
		stat.out_free  = out_free;
		stat.held_zero = count_q == '0;
		stat.len_zero  = len_rd == '0;
		stat.at_last   = (LEN_W'(out_idx_q) + LEN_W'(1)) == len_rd;
	end

	// count after an accepted item
	always_comb begin
		count_nx = count_q;
		if (cmd.take) begin
			case (op)
				OP_PUSH:  if (commit) count_nx = count_q + CNT_W'(1);
				OP_POP:   if (count_q != '0) count_nx = count_q - CNT_W'(1);
				OP_CLEAR: count_nx = '0;
				default:  count_nx = count_q;
			endcase
		end
	end

	// result selection
	always_comb begin
		res_load   = 1'b0;
		res_status = ST_OK;
		res_byte   = '0;
		res_bvalid = 1'b0;
		res_last   = 1'b1;
		res_len    = '0;
		res_cnt    = count_nx;
		if (cmd.take) begin
			case (op)
				OP_PUSH: begin
					res_load = last_byte;
					if (full) begin
						res_status = ST_FULL;
					end else if (ovl_new) begin
						res_status = ST_TOOLONG;
					end else begin
						res_len = part_inc;
					end
				end
				OP_POP: begin
					res_load   = count_q == '0;
					res_status = ST_EMPTY;
				end
				OP_CLEAR: res_load = 1'b1;
				default:  res_load = 1'b0;
			endcase
		end else if (cmd.pop_zero) begin
			res_load = 1'b1;
		end else if (cmd.stream_load) begin
			res_load   = 1'b1;
			res_byte   = byte_rd;
			res_bvalid = 1'b1;
			res_last   = stat.at_last;
			res_len    = len_rd;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q     <= SLOTS_RESET;
			limit_q     <= LIMIT_RESET;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			pop_slot_q  <= '0;
			count_q     <= '0;
			partial_q   <= '0;
			overlong_q  <= 1'b0;
			out_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_SLOTS: slots_q <= cfg_data[CNT_W-1:0];
					REG_LIMIT: limit_q <= cfg_data[LEN_W-1:0];
					default:   limit_q <= limit_q;
				endcase
			end
			count_q <= count_nx;
			// item handling
			if (cmd.take) begin
				case (op)
					OP_PUSH: begin
						if (last_byte) begin
							partial_q  <= '0;
							overlong_q <= 1'b0;
						end else begin
							partial_q  <= part_inc;
							overlong_q <= ovl_new;
						end
						if (commit) begin
							wr_ptr_q <= advance(wr_ptr_q, eff_slots);
						end
					end
					OP_POP: begin
						if (count_q != '0) begin
							pop_slot_q <= rd_ptr_q;
							rd_ptr_q   <= advance(rd_ptr_q, eff_slots);
						end
					end
					OP_CLEAR: begin
						wr_ptr_q   <= '0;
						rd_ptr_q   <= '0;
						partial_q  <= '0;
						overlong_q <= 1'b0;
					end
					default: begin
						partial_q <= partial_q;
					end
				endcase
			end
			// byte fetch index
			if (cmd.pop_first) begin
				out_idx_q <= '0;
			end else if (cmd.stream_load && !stat.at_last) begin
				out_idx_q <= out_idx_q + PW'(1);
			end
			// result handshake
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			byte_q   <= res_byte;
			bvalid_q <= res_bvalid;
			last_q   <= res_last;
			len_q    <= res_len;
			cnt_q    <= res_cnt;
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = status_q;
	assign out_byte      = byte_q;
	assign out_valid     = bvalid_q;
	assign out_last      = last_q;
	assign record_length = len_q;
	assign record_count  = cnt_q;

endmodule

// ===== rtl/record_slot_fifo_top.sv =====
// record_slot_fifo_top: fifo of variable-length byte records in fixed slots
// depends on rsf_pkg, rsf_ctrl, rsf_dp (which holds the rsf_ram instances)
//
//  channel  handshake             payload
//  cfg      cfg_we                cfg_index, cfg_data
//  in       in_valid / in_ready   operation, data_byte, byte_valid, last_byte
//  res      res_valid / res_ready status, out_byte, out_valid, out_last,
//                                 record_length, record_count
//
// push bytes, push ends, clears and empty pops are taken whenever in_ready is high.
// a pop of a held record does the registered length memory read, then the
// registered byte memory read, then one byte a cycle while res_ready allows.
// asynchronous reset empties the fifo and restores slots 8, limit 64.
// a result waiting in the output register blocks new items only when
// res_ready is low; a stalled pop stream holds its fetched byte.
module record_slot_fifo_top import rsf_pkg::*; #(
	parameter int MAX_SLOTS  = 8,
	parameter int MAX_RECORD = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              byte_valid,
	input  logic              last_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_valid,
	output logic              out_last,
	output logic [LEN_W-1:0]  record_length,
	output logic [CNT_W-1:0]  record_count
);

	cmd_t  cmd;
	stat_t stat;

	// controller
	rsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath
	rsf_dp #(.MAX_SLOTS(MAX_SLOTS), .MAX_RECORD(MAX_RECORD)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.last_byte     (last_byte),
		.cmd           (cmd),
		.stat          (stat),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.status        (status),
		.out_byte      (out_byte),
		.out_valid     (out_valid),
		.out_last      (out_last),
		.record_length (record_length),
		.record_count  (record_count)
	);

endmodule
